// ===== sv/stw_pkg.sv =====
package stw_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        K_APPEND,
        K_LOAD,
        K_CLEAR,
        K_STATUS
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_CHK,
        S_PUSH,
        S_BK_RD,
        S_BK_CHK,
        S_REP_RD,
        S_REP
    } state_t;

    localparam logic [31:0] WINDOW_RESET = 32'd1000;

endpackage

// ===== sv/stw_channels.sv =====
interface stw_sample_if #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic [TIME_BITS-1:0]         sample_time;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         value_finite;

    modport source (output valid, operation, sample_time, sample_value, value_finite,
                    input ready);
    modport sink (input valid, operation, sample_time, sample_value, value_finite,
                  output ready);
endinterface

interface stw_result_if #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 16,
    parameter int CNT_BITS   = 11
);
    logic                         valid;
    logic                         ready;
    logic [CNT_BITS-1:0]          point_count;
    logic                         window_empty;
    logic [TIME_BITS-1:0]         first_time;
    logic [TIME_BITS-1:0]         last_time;
    logic signed [VALUE_BITS-1:0] value_min;
    logic signed [VALUE_BITS-1:0] value_max;
    logic                         y_valid;
    logic                         overflow;

    modport source (output valid, point_count, window_empty, first_time, last_time,
                    value_min, value_max, y_valid, overflow, input ready);
    modport sink (input valid, point_count, window_empty, first_time, last_time,
                  value_min, value_max, y_valid, overflow, output ready);
endinterface

interface stw_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] window_length;

    modport source (output valid, window_length, input ready);
    modport sink (input valid, window_length, output ready);
endinterface

// ===== sv/stw_ram.sv =====
module stw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/stw_front.sv =====
module stw_front
    import stw_pkg::*;
#(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   operation,
    input  logic [TIME_BITS-1:0]         sample_time,
    input  logic signed [VALUE_BITS-1:0] sample_value,
    input  logic                         value_finite,
    input  logic [31:0]                  window_length,
    output logic                         q_valid,
    input  logic                         q_ready,
    output kind_t                        q_kind,
    output logic [TIME_BITS-1:0]         q_time,
    output logic signed [VALUE_BITS-1:0] q_value,
    output logic                         q_finite,
    output logic [TIME_BITS-1:0]         q_cutoff
);

    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    kind_t                        kind_mem  [2];
    logic [TIME_BITS-1:0]         time_mem  [2];
    logic signed [VALUE_BITS-1:0] value_mem [2];
    logic                         fin_mem   [2];
    logic [TIME_BITS-1:0]         cut_mem   [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    kind_t                in_kind;
    logic [CW-1:0]        time_x;
    logic [CW-1:0]        wl_x;
    logic [TIME_BITS-1:0] cutoff;
    logic                 push;
    logic                 pop;

    always_comb
    begin
        unique case (op_t'(operation))
            OP_APPEND: in_kind = K_APPEND;
            OP_LOAD:   in_kind = K_LOAD;
            OP_CLEAR:  in_kind = K_CLEAR;
            default:   in_kind = K_STATUS;
        endcase
    end

    // Cutoff saturates at zero when the window reaches back past time zero.
    assign time_x = CW'(sample_time);
    assign wl_x   = CW'(window_length);
    assign cutoff = (time_x >= wl_x) ? TIME_BITS'(time_x - wl_x) : '0;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    assign q_kind   = kind_mem[rd_ptr_reg];
    assign q_time   = time_mem[rd_ptr_reg];
    assign q_value  = value_mem[rd_ptr_reg];
    assign q_finite = fin_mem[rd_ptr_reg];
    assign q_cutoff = cut_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_mem[wr_ptr_reg]  <= in_kind;
            time_mem[wr_ptr_reg]  <= sample_time;
            value_mem[wr_ptr_reg] <= sample_value;
            fin_mem[wr_ptr_reg]   <= value_finite;
            cut_mem[wr_ptr_reg]   <= cutoff;
        end
    end

endmodule

// ===== sv/stw_back.sv =====
module stw_back
    import stw_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  kind_t                              q_kind,
    input  logic [TIME_BITS-1:0]               q_time,
    input  logic signed [VALUE_BITS-1:0]       q_value,
    input  logic                               q_finite,
    input  logic [TIME_BITS-1:0]               q_cutoff,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic [$clog2(DEPTH+1)-1:0]         point_count,
    output logic                               window_empty,
    output logic [TIME_BITS-1:0]               first_time,
    output logic [TIME_BITS-1:0]               last_time,
    output logic signed [VALUE_BITS-1:0]       value_min,
    output logic signed [VALUE_BITS-1:0]       value_max,
    output logic                               y_valid,
    output logic                               overflow
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = IDX_W + VALUE_BITS;
    localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] FULL    = CNT_W'(DEPTH);

    // Sums of a pointer and a count stay below twice the depth.
    function automatic logic [IDX_W-1:0] wrap(input logic [CNT_W:0] s);
        logic [CNT_W:0] r;
        r = (s >= DEPTH_X) ? s - DEPTH_X : s;
        return r[IDX_W-1:0];
    endfunction

    state_t                       state_reg, state_next;
    kind_t                        kind_reg, kind_next;
    logic [TIME_BITS-1:0]         t_reg, t_next;
    logic signed [VALUE_BITS-1:0] v_reg, v_next;
    logic                         fin_reg, fin_next;
    logic [TIME_BITS-1:0]         cut_reg, cut_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [IDX_W-1:0]             mh_reg, mh_next;
    logic [CNT_W-1:0]             mc_reg, mc_next;
    logic [IDX_W-1:0]             xh_reg, xh_next;
    logic [CNT_W-1:0]             xc_reg, xc_next;
    logic [TIME_BITS-1:0]         last_reg, last_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;
    logic                         ovf_reg, ovf_next;
    logic                         mdone_reg, mdone_next;
    logic                         xdone_reg, xdone_next;
    logic                         rv_reg, rv_next;

    logic [CNT_W-1:0]             o_cnt_reg, o_cnt_next;
    logic                         o_empty_reg, o_empty_next;
    logic [TIME_BITS-1:0]         o_first_reg, o_first_next;
    logic [TIME_BITS-1:0]         o_last_reg, o_last_next;
    logic signed [VALUE_BITS-1:0] o_min_reg, o_min_next;
    logic signed [VALUE_BITS-1:0] o_max_reg, o_max_next;
    logic                         o_yv_reg, o_yv_next;
    logic                         o_ovf_reg, o_ovf_next;

    logic                 t_we, t_re;
    logic [IDX_W-1:0]     t_waddr;
    logic [TIME_BITS-1:0] t_rdata;
    logic                 m_we, m_re, x_we, x_re;
    logic [IDX_W-1:0]     m_waddr, m_raddr, x_waddr, x_raddr;
    logic [ENT_W-1:0]     m_wdata, x_wdata, m_rdata, x_rdata;

    logic                         expire;
    logic                         full;
    logic signed [VALUE_BITS-1:0] m_val, x_val;
    logic [IDX_W-1:0]             m_slot, x_slot;
    logic [IDX_W-1:0]             head_inc, mh_inc, xh_inc;
    logic [IDX_W-1:0]             m_back, x_back;
    logic                         load_out;

    stw_ram #(.WIDTH(TIME_BITS), .DEPTH(DEPTH)) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_reg),
        .re    (t_re),
        .raddr (head_reg),
        .rdata (t_rdata)
    );

    stw_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_min_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    stw_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_max_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_waddr),
        .wdata (x_wdata),
        .re    (x_re),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    assign m_val    = $signed(m_rdata[VALUE_BITS-1:0]);
    assign x_val    = $signed(x_rdata[VALUE_BITS-1:0]);
    assign m_slot   = m_rdata[ENT_W-1:VALUE_BITS];
    assign x_slot   = x_rdata[ENT_W-1:VALUE_BITS];
    assign head_inc = wrap((CNT_W + 1)'(head_reg) + (CNT_W + 1)'(1));
    assign mh_inc   = wrap((CNT_W + 1)'(mh_reg) + (CNT_W + 1)'(1));
    assign xh_inc   = wrap((CNT_W + 1)'(xh_reg) + (CNT_W + 1)'(1));
    assign m_back   = wrap((CNT_W + 1)'(mh_reg) + (CNT_W + 1)'(mc_reg) - (CNT_W + 1)'(1));
    assign x_back   = wrap((CNT_W + 1)'(xh_reg) + (CNT_W + 1)'(xc_reg) - (CNT_W + 1)'(1));
    assign expire   = (kind_reg == K_APPEND) && (cnt_reg != '0) && (t_rdata < cut_reg);
    assign full     = (cnt_reg == FULL);
    assign load_out = (state_reg == S_REP) && (!rv_reg || res_ready);
    assign m_wdata  = {slot_reg, v_reg};
    assign x_wdata  = {slot_reg, v_reg};
    assign m_waddr  = wrap((CNT_W + 1)'(mh_reg) + (CNT_W + 1)'(mc_reg));
    assign x_waddr  = wrap((CNT_W + 1)'(xh_reg) + (CNT_W + 1)'(xc_reg));

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        t_next     = t_reg;
        v_next     = v_reg;
        fin_next   = fin_reg;
        cut_next   = cut_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        mh_next    = mh_reg;
        mc_next    = mc_reg;
        xh_next    = xh_reg;
        xc_next    = xc_reg;
        last_next  = last_reg;
        slot_next  = slot_reg;
        ovf_next   = ovf_reg;
        mdone_next = mdone_reg;
        xdone_next = xdone_reg;
        rv_next    = (rv_reg && res_ready) ? 1'b0 : rv_reg;

        o_cnt_next   = o_cnt_reg;
        o_empty_next = o_empty_reg;
        o_first_next = o_first_reg;
        o_last_next  = o_last_reg;
        o_min_next   = o_min_reg;
        o_max_next   = o_max_reg;
        o_yv_next    = o_yv_reg;
        o_ovf_next   = o_ovf_reg;

        q_ready = 1'b0;
        t_we    = 1'b0;
        t_re    = 1'b0;
        t_waddr = wrap((CNT_W + 1)'(head_reg) + (CNT_W + 1)'(cnt_reg));
        m_we    = 1'b0;
        m_re    = 1'b0;
        m_raddr = mh_reg;
        x_we    = 1'b0;
        x_re    = 1'b0;
        x_raddr = xh_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    kind_next = q_kind;
                    t_next    = q_time;
                    v_next    = q_value;
                    fin_next  = q_finite;
                    cut_next  = q_cutoff;
                    ovf_next  = 1'b0;
                    unique case (q_kind)
                        K_APPEND, K_LOAD:
                        begin
                            state_next = S_EXP_RD;
                        end
                        K_CLEAR:
                        begin
                            head_next  = '0;
                            cnt_next   = '0;
                            mh_next    = '0;
                            mc_next    = '0;
                            xh_next    = '0;
                            xc_next    = '0;
                            state_next = S_REP_RD;
                        end
                        default:
                        begin
                            state_next = S_REP_RD;
                        end
                    endcase
                end
            end
            S_EXP_RD:
            begin
                t_re       = 1'b1;
                m_re       = 1'b1;
                x_re       = 1'b1;
                state_next = S_EXP_CHK;
            end
            S_EXP_CHK:
            begin
                // Expiry and the full-store drop both remove the oldest sample.
                if (expire || full)
                begin
                    if ((mc_reg != '0) && (m_slot == head_reg))
                    begin
                        mh_next = mh_inc;
                        mc_next = mc_reg - CNT_W'(1);
                    end
                    if ((xc_reg != '0) && (x_slot == head_reg))
                    begin
                        xh_next = xh_inc;
                        xc_next = xc_reg - CNT_W'(1);
                    end
                    head_next = head_inc;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (expire)
                    begin
                        state_next = S_EXP_RD;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                t_we       = 1'b1;
                slot_next  = t_waddr;
                cnt_next   = cnt_reg + CNT_W'(1);
                last_next  = t_reg;
                mdone_next = 1'b0;
                xdone_next = 1'b0;
                state_next = fin_reg ? S_BK_RD : S_REP_RD;
            end
            S_BK_RD:
            begin
                m_re       = 1'b1;
                m_raddr    = m_back;
                x_re       = 1'b1;
                x_raddr    = x_back;
                state_next = S_BK_CHK;
            end
            S_BK_CHK:
            begin
                if (!mdone_reg)
                begin
                    if ((mc_reg != '0) && (m_val >= v_reg))
                    begin
                        mc_next = mc_reg - CNT_W'(1);
                    end
                    else
                    begin
                        m_we       = 1'b1;
                        mc_next    = mc_reg + CNT_W'(1);
                        mdone_next = 1'b1;
                    end
                end
                if (!xdone_reg)
                begin
                    if ((xc_reg != '0) && (x_val <= v_reg))
                    begin
                        xc_next = xc_reg - CNT_W'(1);
                    end
                    else
                    begin
                        x_we       = 1'b1;
                        xc_next    = xc_reg + CNT_W'(1);
                        xdone_next = 1'b1;
                    end
                end
                state_next = (mdone_next && xdone_next) ? S_REP_RD : S_BK_RD;
            end
            S_REP_RD:
            begin
                t_re       = 1'b1;
                m_re       = 1'b1;
                x_re       = 1'b1;
                state_next = S_REP;
            end
            S_REP:
            begin
                if (load_out)
                begin
                    rv_next      = 1'b1;
                    o_cnt_next   = cnt_reg;
                    o_empty_next = (cnt_reg == '0);
                    o_first_next = (cnt_reg != '0) ? t_rdata : '0;
                    o_last_next  = (cnt_reg != '0) ? last_reg : '0;
                    o_yv_next    = (mc_reg != '0);
                    o_min_next   = (mc_reg != '0) ? m_val : '0;
                    o_max_next   = (xc_reg != '0) ? x_val : '0;
                    o_ovf_next   = ovf_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            mh_reg    <= '0;
            mc_reg    <= '0;
            xh_reg    <= '0;
            xc_reg    <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            mh_reg    <= mh_next;
            mc_reg    <= mc_next;
            xh_reg    <= xh_next;
            xc_reg    <= xc_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        t_reg       <= t_next;
        v_reg       <= v_next;
        fin_reg     <= fin_next;
        cut_reg     <= cut_next;
        last_reg    <= last_next;
        slot_reg    <= slot_next;
        ovf_reg     <= ovf_next;
        mdone_reg   <= mdone_next;
        xdone_reg   <= xdone_next;
        o_cnt_reg   <= o_cnt_next;
        o_empty_reg <= o_empty_next;
        o_first_reg <= o_first_next;
        o_last_reg  <= o_last_next;
        o_min_reg   <= o_min_next;
        o_max_reg   <= o_max_next;
        o_yv_reg    <= o_yv_next;
        o_ovf_reg   <= o_ovf_next;
    end

    assign res_valid    = rv_reg;
    assign point_count  = o_cnt_reg;
    assign window_empty = o_empty_reg;
    assign first_time   = o_first_reg;
    assign last_time    = o_last_reg;
    assign value_min    = o_min_reg;
    assign value_max    = o_max_reg;
    assign y_valid      = o_yv_reg;
    assign overflow     = o_ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= FULL)
        else $error("sample count exceeds the store depth");

    assert property (@(posedge clk) disable iff (!rst_n) (mc_reg <= cnt_reg) && (xc_reg <= cnt_reg))
        else $error("deque holds more entries than the window");

    // The two deques may pop different numbers of entries from their backs, so they agree only between items.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_IDLE) |-> ((mc_reg == '0) == (xc_reg == '0)))
        else $error("min and max deques disagree on emptiness");

    assert property (@(posedge clk) disable iff (!rst_n) load_out |=> (rv_reg && state_reg == S_IDLE))
        else $error("result not presented after the report step");

endmodule

// ===== sv/sliding_time_window_min_max.sv =====
// Sliding time-window minimum and maximum tracker.
// Samples arrive on the smp channel (operation, sample_time, sample_value,
// value_finite); each accepted transfer yields exactly one status transfer on
// the res channel, in order. The cfg channel writes window_length and is always
// ready; write it only while the block is idle.
// A two-entry command queue feeds a sequencer. A status or clear item takes a
// read step and a report step. An append or load first reads the oldest stored
// time and drops the oldest sample while it has expired (append only) or once if
// the store is full, then writes the sample; a finite value then pops the deque
// backs in rounds (both deques pop in the same round) before the report steps.
// The store memory and the two deque memories each have one registered read port.
// The result register lets the sequencer take the next item from the queue
// while a status waits; when the receiver stalls, the sequencer stops at its
// next report and the queue then fills and lowers smp.ready.
// Reset empties the window and sets window_length to 1000; store contents are
// not cleared and are only read after being written.
module sliding_time_window_min_max
    import stw_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    stw_sample_if.sink     smp,
    stw_result_if.source   res,
    stw_cfg_if.sink        cfg
);

    logic [31:0]                  wl_reg;
    logic                         q_valid;
    logic                         q_ready;
    kind_t                        q_kind;
    logic [TIME_BITS-1:0]         q_time;
    logic signed [VALUE_BITS-1:0] q_value;
    logic                         q_finite;
    logic [TIME_BITS-1:0]         q_cutoff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= WINDOW_RESET;
        end
        else if (cfg.valid)
        begin
            wl_reg <= cfg.window_length;
        end
    end

    stw_front #(.TIME_BITS(TIME_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (smp.valid),
        .in_ready      (smp.ready),
        .operation     (smp.operation),
        .sample_time   (smp.sample_time),
        .sample_value  (smp.sample_value),
        .value_finite  (smp.value_finite),
        .window_length (wl_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_kind        (q_kind),
        .q_time        (q_time),
        .q_value       (q_value),
        .q_finite      (q_finite),
        .q_cutoff      (q_cutoff)
    );

    stw_back #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_kind       (q_kind),
        .q_time       (q_time),
        .q_value      (q_value),
        .q_finite     (q_finite),
        .q_cutoff     (q_cutoff),
        .res_valid    (res.valid),
        .res_ready    (res.ready),
        .point_count  (res.point_count),
        .window_empty (res.window_empty),
        .first_time   (res.first_time),
        .last_time    (res.last_time),
        .value_min    (res.value_min),
        .value_max    (res.value_max),
        .y_valid      (res.y_valid),
        .overflow     (res.overflow)
    );

endmodule

// ===== sim/stw_tb_channels.sv =====
`timescale 1ns / 100ps

// Bundles of the three channels are taken from the RTL interface file; this file
// only holds the expected-result record shared by the bench.
package stw_tb_types;

    typedef struct packed {
        logic [10:0]        point_count;
        logic               window_empty;
        logic [31:0]        first_time;
        logic [31:0]        last_time;
        logic signed [15:0] value_min;
        logic signed [15:0] value_max;
        logic               y_valid;
        logic               overflow;
    } status_t;

endpackage

// ===== sim/sliding_time_window_min_max_tb.sv =====
`timescale 1ns / 100ps

module sliding_time_window_min_max_tb;
    import stw_pkg::*;
    import stw_tb_types::*;

    localparam int DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stw_sample_if #(32, 16) smp ();
    stw_result_if #(32, 16, 11) res ();
    stw_cfg_if cfg ();

    sliding_time_window_min_max #(.DEPTH(DEPTH), .TIME_BITS(32), .VALUE_BITS(16)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Own copy of the window state.
    logic [31:0]        win_len;
    logic [31:0]        w_time [DEPTH];
    logic signed [15:0] w_val [DEPTH];
    logic               w_fin [DEPTH];
    int                 w_head;
    int                 w_count;
    int                 min_idx [$];
    int                 max_idx [$];

    status_t status_queue [$];
    int  mismatches = 0;
    int  idle_send_pct = 0;
    int  stall_recv_pct = 0;
    int  quiet_cycles = 0;
    logic [31:0] time_now = 32'd0;

    function automatic void window_clear();
        w_head = 0;
        w_count = 0;
        min_idx.delete();
        max_idx.delete();
    endfunction

    function automatic void drop_oldest_sample();
        if (min_idx.size() > 0 && min_idx[0] == w_head)
            min_idx.delete(0);
        if (max_idx.size() > 0 && max_idx[0] == w_head)
            max_idx.delete(0);
        w_head = (w_head + 1) % DEPTH;
        w_count--;
    endfunction

    function automatic status_t window_status(logic [1:0] op, logic [31:0] t,
                                              logic signed [15:0] v, logic fin);
        status_t s;
        logic [31:0] cutoff;
        int slot;
        s = '0;
        if (op == OP_APPEND)
        begin
            cutoff = (t >= win_len) ? t - win_len : 32'd0;
            while (w_count > 0 && w_time[w_head] < cutoff)
                drop_oldest_sample();
        end
        if (op == OP_APPEND || op == OP_LOAD)
        begin
            if (w_count >= DEPTH)
            begin
                drop_oldest_sample();
                s.overflow = 1'b1;
            end
            slot = (w_head + w_count) % DEPTH;
            w_time[slot] = t;
            w_val[slot] = v;
            w_fin[slot] = fin;
            w_count++;
            if (fin)
            begin
                while (min_idx.size() > 0 && w_val[min_idx[$]] >= v)
                    void'(min_idx.pop_back());
                min_idx = {min_idx, slot};
                while (max_idx.size() > 0 && w_val[max_idx[$]] <= v)
                    void'(max_idx.pop_back());
                max_idx = {max_idx, slot};
            end
        end
        else if (op == OP_CLEAR)
            window_clear();
        s.point_count = w_count[10:0];
        s.window_empty = (w_count == 0);
        if (w_count > 0)
        begin
            s.first_time = w_time[w_head];
            s.last_time = w_time[(w_head + w_count - 1) % DEPTH];
        end
        s.y_valid = (min_idx.size() > 0);
        if (s.y_valid)
        begin
            s.value_min = w_val[min_idx[0]];
            s.value_max = w_val[max_idx[0]];
        end
        return s;
    endfunction

    // Sends one item; a directed expectation, when given, must agree with the predictor.
    // Valid stays high from the previous transfer when this item follows at once.
    task automatic send_sample(logic [1:0] op, logic [31:0] t, logic signed [15:0] v,
                               logic fin, bit has_fixed = 0, status_t fixed = '0);
        status_t p;
        if ($urandom_range(99) < idle_send_pct)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_send_pct)
                @(posedge clk);
        end
        smp.valid <= 1'b1;
        smp.operation <= op;
        smp.sample_time <= t;
        smp.sample_value <= v;
        smp.value_finite <= fin;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        p = window_status(op, t, v, fin);
        if (has_fixed && p != fixed)
            $display("directed row disagrees with predictor: %h vs %h", fixed, p);
        status_queue = {status_queue, (has_fixed ? fixed : p)};
    endtask

    task automatic write_window(logic [31:0] len);
        smp.valid <= 1'b0;
        while (status_queue.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.window_length <= len;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        win_len = len;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            res.ready <= ($urandom_range(99) >= stall_recv_pct);
    end

    always @(posedge clk)
    begin
        status_t exp_s;
        if (rst_n && res.valid && res.ready)
        begin
            if (status_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status transfer");
            end
            else
            begin
                exp_s = status_queue[0];
                status_queue.delete(0);
                if (exp_s !== {res.point_count, res.window_empty, res.first_time,
                               res.last_time, res.value_min, res.value_max,
                               res.y_valid, res.overflow})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status mismatch: exp cnt=%0d emp=%b ft=%0d lt=%0d min=%0d max=%0d yv=%b ov=%b, got cnt=%0d emp=%b ft=%0d lt=%0d min=%0d max=%0d yv=%b ov=%b",
                            exp_s.point_count, exp_s.window_empty, exp_s.first_time,
                            exp_s.last_time, exp_s.value_min, exp_s.value_max,
                            exp_s.y_valid, exp_s.overflow, res.point_count,
                            res.window_empty, res.first_time, res.last_time,
                            res.value_min, res.value_max, res.y_valid, res.overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    typedef struct {
        logic [1:0]         op;
        logic [31:0]        t;
        logic signed [15:0] v;
        logic               fin;
        bit                 has_fixed;
        status_t            fixed;
    } row_t;

    row_t rows [] = '{
        '{OP_UNUSED, 32'd5, 16'sd3, 1'b1, 1, '{11'd0, 1'b1, 32'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 1'b0}},
        '{OP_APPEND, 32'd0, -16'sd32768, 1'b1, 1, '{11'd1, 1'b0, 32'd0, 32'd0, -16'sd32768, -16'sd32768, 1'b1, 1'b0}},
        '{OP_APPEND, 32'd10, 16'sd32767, 1'b1, 1, '{11'd2, 1'b0, 32'd0, 32'd10, -16'sd32768, 16'sd32767, 1'b1, 1'b0}},
        '{OP_APPEND, 32'd20, 16'sd32767, 1'b1, 0, '0},
        '{OP_APPEND, 32'd30, 16'sd100, 1'b0, 0, '0},
        '{OP_LOAD, 32'd40, -16'sd32768, 1'b1, 0, '0},
        '{OP_UNUSED, 32'd50, 16'sd7, 1'b0, 0, '0},
        '{OP_APPEND, 32'd1500, 16'sd5, 1'b1, 0, '0},
        '{OP_APPEND, 32'd1500, -16'sd1, 1'b0, 0, '0},
        '{OP_LOAD, 32'd1400, 16'sd9, 1'b1, 0, '0},
        '{OP_APPEND, 32'd5000, 16'sd0, 1'b0, 0, '0},
        '{OP_CLEAR, 32'hFFFF_FFFF, -16'sd1, 1'b1, 1, '{11'd0, 1'b1, 32'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 1'b0}},
        '{OP_APPEND, 32'hFFFF_FFFF, -16'sd1, 1'b1, 1, '{11'd1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd1, -16'sd1, 1'b1, 1'b0}},
        '{OP_APPEND, 32'hFFFF_FFFF, 16'sd21845, 1'b1, 0, '0},
        '{OP_CLEAR, 32'd0, 16'sd0, 1'b0, 0, '0}
    };

    task automatic random_phase(int n, int max_step);
        logic [1:0] op;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            op = (r < 70) ? OP_APPEND : (r < 90) ? OP_LOAD : (r < 96) ? OP_CLEAR : OP_UNUSED;
            if ($urandom_range(15) == 0)
                time_now = $urandom();
            else
                time_now = time_now + $urandom_range(max_step);
            send_sample(op, time_now, 16'($urandom()), $urandom_range(9) != 0);
        end
    endtask

    initial
    begin
        smp.valid = 1'b0;
        smp.operation = OP_APPEND;
        smp.sample_time = '0;
        smp.sample_value = '0;
        smp.value_finite = 1'b0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.window_length = '0;
        win_len = WINDOW_RESET;
        window_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_sample(rows[i].op, rows[i].t, rows[i].v, rows[i].fin,
                        rows[i].has_fixed, rows[i].fixed);

        // Fill past the store depth with no expiry to reach overflow.
        write_window(32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH + 5; i++)
            send_sample(OP_LOAD, 32'(i), 16'($urandom()), $urandom_range(3) != 0);
        send_sample(OP_CLEAR, 32'd0, 16'sd0, 1'b0);

        write_window(32'd0);
        time_now = 32'd0;
        random_phase(150, 3);

        idle_send_pct = 78;
        write_window(32'd50);
        random_phase(150, 10);

        idle_send_pct = 0;
        stall_recv_pct = 78;
        write_window($urandom_range(200, 2000));
        random_phase(150, 20);

        idle_send_pct = 11;
        stall_recv_pct = 11;
        write_window(WINDOW_RESET);
        random_phase(150, 30);

        idle_send_pct = 0;
        stall_recv_pct = 0;
        write_window($urandom());
        random_phase(100, 1000);

        smp.valid <= 1'b0;
        while (status_queue.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/stw_pkg.sv
sv/stw_channels.sv
sv/stw_ram.sv
sv/stw_front.sv
sv/stw_back.sv
sv/sliding_time_window_min_max.sv
sim/stw_tb_channels.sv
sim/sliding_time_window_min_max_tb.sv
